// ===== hdl/list_append_search_delete_top_defines.svh =====
// ---------------------------------------------------------------------------
// list_append_search_delete_top_defines
// Assertion macros shared by the list block; clk and rst_n are taken from
// the scope of the module that uses them.
// ---------------------------------------------------------------------------
`ifndef LIST_APPEND_SEARCH_DELETE_TOP_DEFINES_SVH
`define LIST_APPEND_SEARCH_DELETE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LASD_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LASD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lasd_pkg.sv =====
// ---------------------------------------------------------------------------
// lasd_pkg
// Shared types and codes for the bounded list with linear search.
// ---------------------------------------------------------------------------
package lasd_pkg;

  // stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 6;
  localparam int LEN_W       = 7;

  // request codes carried in tuser
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_APPEND = 2'd0;
  localparam mode_t MODE_SEARCH = 2'd1;
  localparam mode_t MODE_DELETE = 2'd2;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } fsm_state_t;

  // controller to datapath
  typedef struct packed {
    logic    latch;       // capture the incoming word
    logic    append;      // write value at the tail, bump count
    logic    scan_start;  // index to zero, read entry zero
    logic    scan_step;   // advance the scan index
    logic    rd;          // issue a store read this cycle
    logic    mark_hit;    // record match position and found flag
    logic    shift_step;  // move one entry down, advance index
    logic    count_dec;   // one entry removed
    logic    set_status;  // load status_code into the result
    status_t status_code;
    logic    out_load;    // move the result into the output register
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  empty;
    logic  match;
    logic  scan_last;
    logic  shift_last;
    logic  out_free;
  } dp_stat_t;

endpackage

// ===== hdl/lasd_dpath.sv =====
// ---------------------------------------------------------------------------
// lasd_dpath
// Entry store, count, scan index and result/output registers of the list.
// ---------------------------------------------------------------------------
module lasd_dpath #(
  parameter int CAPACITY = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lasd_pkg::ctl_cmd_t               cmd,
  output lasd_pkg::dp_stat_t               stat,
  input  logic [lasd_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [lasd_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lasd_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lasd_pkg::*;

  localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int CW1 = CW + 1;

  // entry store
  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rdata_r;

  logic [VALUE_W-1:0] value_r;
  mode_t              mode_r;
  logic [CW-1:0]      count_r;
  logic [IW-1:0]      idx_r;
  logic [IW-1:0]      pos_r;
  status_t            status_r;
  logic               found_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [CW1-1:0]     idx_p1;
  logic [CW1-1:0]     idx_p2;
  logic [CW1-1:0]     cnt_w;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic [IW-1:0]      rd_addr;
  logic [31:0]        pos_ext;
  logic [31:0]        len_ext;

  // index arithmetic
  assign idx_p1 = CW1'(idx_r) + CW1'(1);
  assign idx_p2 = CW1'(idx_r) + CW1'(2);
  assign cnt_w  = CW1'(count_r);

  // store port selection
  assign wr_en   = cmd.append | cmd.shift_step;
  assign wr_addr = cmd.append ? count_r[IW-1:0] : idx_r;
  assign wr_data = cmd.append ? value_r : rdata_r;
  assign rd_addr = cmd.scan_start ? '0 :
                   cmd.shift_step ? idx_p2[IW-1:0] : idx_p1[IW-1:0];

  // store write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // store read, registered
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // request and result registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      value_r  <= in_tdata[VALUE_W-1:0];
      mode_r   <= in_tuser;
      status_r <= ST_DONE;
      found_r  <= 1'b0;
      pos_r    <= '0;
    end else begin
      if (cmd.append) begin
        pos_r <= count_r[IW-1:0];
      end
      if (cmd.mark_hit) begin
        found_r <= 1'b1;
        pos_r   <= idx_r;
      end
      if (cmd.set_status) begin
        status_r <= cmd.status_code;
      end
    end
  end

  // scan / shift index
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx_r <= '0;
    end else if (cmd.scan_step || cmd.shift_step) begin
      idx_r <= idx_p1[IW-1:0];
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.append) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.count_dec) begin
      count_r <= count_r - CW'(1);
    end
  end

  // result word fields
  assign pos_ext = 32'(pos_r);
  assign len_ext = 32'(count_r);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {len_ext[LEN_W-1:0], pos_ext[POS_W-1:0], found_r, status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // status to controller
  always_comb begin
    stat.mode       = mode_r;
    stat.full       = (count_r == CW'(CAPACITY));
    stat.empty      = (count_r == '0);
    stat.match      = (rdata_r == value_r);
    stat.scan_last  = (idx_p1 >= cnt_w);
    stat.shift_last = (idx_p2 >= cnt_w);
    stat.out_free   = !out_valid_r || out_tready;
  end

endmodule

// ===== hdl/lasd_ctrl.sv =====
// ---------------------------------------------------------------------------
// lasd_ctrl
// Sequencer for append, linear search and delete-with-shift.
// ---------------------------------------------------------------------------
module lasd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  lasd_pkg::dp_stat_t stat,
  output lasd_pkg::ctl_cmd_t cmd
);
  import lasd_pkg::*;

  fsm_state_t state_r;
  fsm_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.status_code = ST_DONE;
    in_tready       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_DONE;
        case (stat.mode)
          MODE_APPEND: begin
            if (stat.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
            end else begin
              cmd.append = 1'b1;
            end
          end
          MODE_SEARCH, MODE_DELETE: begin
            if (stat.empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_MISSING;
            end else begin
              cmd.scan_start = 1'b1;
              cmd.rd         = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        // fetch the next entry while the current one is compared
        cmd.rd = !stat.scan_last;
        if (stat.match) begin
          cmd.mark_hit = 1'b1;
          if (stat.mode == MODE_DELETE && !stat.scan_last) begin
            state_nxt = S_SHIFT;
          end else begin
            cmd.count_dec = (stat.mode == MODE_DELETE);
            state_nxt     = S_DONE;
          end
        end else if (stat.scan_last) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_MISSING;
          state_nxt       = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        // write entry i from entry i+1, fetch i+2
        cmd.shift_step = 1'b1;
        cmd.rd         = !stat.shift_last;
        if (stat.shift_last) begin
          cmd.count_dec = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/list_append_search_delete_top.sv =====
// ---------------------------------------------------------------------------
// list_append_search_delete_top
// Bounded list of signed 32-bit values: append, first-match search, and
// delete of the first match with the later entries moved down.
// ---------------------------------------------------------------------------
//  channel | dir | handshake           | word
//  in_     | in  | in_tvalid/in_tready | tuser: mode; tdata: value
//  out_    | out | out_tvalid/out_tready | tdata: status, found, position, length
//
//  One word at a time. Append and mode 3 go from dispatch straight to the result.
//  Search reads entries in order from index 0 up to the first match or the end
//  of the list; delete then moves each later entry down one place, in turn,
//  through the single read and single write port of the entry store.
//  Synchronous active-low reset empties the list; the store is not cleared.
//  A result waiting on out_tready does not block the next input word.
// ---------------------------------------------------------------------------
`include "list_append_search_delete_top_defines.svh"

module list_append_search_delete_top #(
  parameter int CAPACITY = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lasd_pkg::IN_TDATA_W-1:0]  in_tdata,   // value[31:0]
  input  logic [lasd_pkg::IN_TUSER_W-1:0]  in_tuser,   // mode[1:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lasd_pkg::OUT_TDATA_W-1:0] out_tdata   // status[1:0], found[2],
                                                       // position[8:3], length[15:9]
);
  import lasd_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // controller
  lasd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  lasd_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // checks
  `LASD_ASSERT_HOLDS(a_load_when_free, cmd.out_load, stat.out_free, "result overwrote pending word")
  `LASD_ASSERT_HOLDS(a_no_append_full, cmd.append, !stat.full, "append into full list")
  `LASD_ASSERT_HOLDS(a_found_is_done, out_tvalid && out_tdata[2], status_t'(out_tdata[1:0]) == ST_DONE, "found with error status")
  `LASD_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted two words back to back")

endmodule
